// ===== hdl/prq_pkg.sv =====
// Shared types, constants and helpers for the pausable request queue.
`timescale 1ns / 1ps
package prq_pkg;

   // Queue geometry
   localparam int QUEUE_DEPTH = 16;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int ID_W        = 32;

   // Request operation codes
   localparam logic [2:0] OP_PUSH   = 3'd0;
   localparam logic [2:0] OP_TAKE   = 3'd1;
   localparam logic [2:0] OP_PAUSE  = 3'd2;
   localparam logic [2:0] OP_RESUME = 3'd3;
   localparam logic [2:0] OP_STOP   = 3'd4;

   // Result kinds
   localparam logic [2:0] KIND_GRANTED  = 3'd0;
   localparam logic [2:0] KIND_NONE     = 3'd1;
   localparam logic [2:0] KIND_RELEASED = 3'd2;
   localparam logic [2:0] KIND_PUSHED   = 3'd3;
   localparam logic [2:0] KIND_FULL     = 3'd4;
   localparam logic [2:0] KIND_ACK      = 3'd5;

   localparam logic [6:0] STOP_CODE = 7'd100;
   localparam logic [6:0] NO_CODE   = 7'd0;

   // Register map
   localparam logic REG_TAKE_LIMIT   = 1'b0;
   localparam logic [7:0] TAKE_LIMIT_RESET = 8'd4;

   // One queue slot
   typedef struct packed {
      logic            hold;
      logic [ID_W-1:0] id;
   } entry_type;

   // Queue memory write and read request
   typedef struct packed {
      logic             wr_en;
      logic [PTR_W-1:0] wr_addr;
      entry_type        wr_data;
      logic             rd_en;
      logic [PTR_W-1:0] rd_addr;
   } mem_req_type;

   // Circular pointer advance
   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

endpackage

// ===== hdl/prq_ram.sv =====
// Queue slot memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps
module prq_ram (
   input  logic                clock,
   input  prq_pkg::mem_req_type mem_req,
   output prq_pkg::entry_type  rd_data
);
   import prq_pkg::*;

   entry_type mem_ff [QUEUE_DEPTH];
   entry_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   // Read port, registered
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/prq_csr.sv =====
// Configuration register block: holds the take limit.
`timescale 1ns / 1ps
module prq_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic [7:0]  take_limit
);
   import prq_pkg::*;

   logic [7:0] take_limit_ff;
   logic [7:0] take_limit_in;
   logic       wr_hit;

   assign csr_pready = 1'b1;
   assign wr_hit = csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr[2] == REG_TAKE_LIMIT);

   // Register update
   always_comb begin
      take_limit_in = take_limit_ff;
      if (wr_hit) begin
         take_limit_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         take_limit_ff <= TAKE_LIMIT_RESET;
      end else begin
         take_limit_ff <= take_limit_in;
      end
   end

   // Read mux
   always_comb begin
      unique case (csr_paddr[2])
         REG_TAKE_LIMIT: csr_prdata = {24'd0, take_limit_ff};
         default:        csr_prdata = 32'd0;
      endcase
   end

   assign take_limit = take_limit_ff;

endmodule

// ===== hdl/prq_ctrl.sv =====
// Queue sequencer: mode, pointers, scan and compaction, drain and result buffer.
`timescale 1ns / 1ps
module prq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            take_limit,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [2:0]            req_op,
   input  logic [prq_pkg::ID_W-1:0] req_request_id,
   input  logic                  req_deferrable,
   input  logic [7:0]            req_active_count,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [2:0]            rsp_kind,
   output logic [prq_pkg::ID_W-1:0] rsp_out_id,
   output logic [6:0]            rsp_release_code,
   output logic                  rsp_last,
   output prq_pkg::mem_req_type  mem_req,
   input  prq_pkg::entry_type    rd_data
);
   import prq_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TAKE_WAIT,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_MOVE_RD,
      ST_MOVE_WR,
      ST_DRAIN_RD,
      ST_DRAIN_WAIT,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      MODE_RUNNING = 2'd0,
      MODE_STOPPED = 2'd1,
      MODE_PAUSED  = 2'd2
   } mode_type;

   state_type        state_ff, state_in;
   mode_type         mode_ff, mode_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] cur_ff, cur_in;
   logic [PTR_W-1:0] idx_ff, idx_in;

   // Pending result, waiting for the output register
   logic [2:0]       pend_kind_ff, pend_kind_in;
   logic [ID_W-1:0]  pend_id_ff, pend_id_in;
   logic [6:0]       pend_code_ff, pend_code_in;
   logic             pend_last_ff, pend_last_in;

   // Output register
   logic             out_valid_ff, out_valid_in;
   logic [2:0]       out_kind_ff, out_kind_in;
   logic [ID_W-1:0]  out_id_ff, out_id_in;
   logic [6:0]       out_code_ff, out_code_in;
   logic             out_last_ff, out_last_in;

   logic             slot_free;
   logic             take_ok;
   logic [CNT_W-1:0] last_idx;

   assign slot_free = !out_valid_ff || rsp_tready;
   assign take_ok   = (req_active_count < take_limit) && (count_ff != '0);
   assign last_idx  = count_ff - CNT_W'(1);

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      pend_kind_in = pend_kind_ff;
      pend_id_in   = pend_id_ff;
      pend_code_in = pend_code_ff;
      pend_last_in = pend_last_ff;
      out_valid_in = out_valid_ff;
      out_kind_in  = out_kind_ff;
      out_id_in    = out_id_ff;
      out_code_in  = out_code_ff;
      out_last_in  = out_last_ff;
      mem_req         = '0;
      mem_req.wr_addr = tail_ff;
      mem_req.rd_addr = head_ff;
      req_tready   = (state_ff == ST_IDLE);

      // Output register drains on handshake
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               pend_id_in   = '0;
               pend_code_in = NO_CODE;
               pend_last_in = 1'b1;
               case (req_op)
                  OP_PUSH: begin
                     if (count_ff < CNT_W'(QUEUE_DEPTH)) begin
                        mem_req.wr_en        = 1'b1;
                        mem_req.wr_data.hold = req_deferrable;
                        mem_req.wr_data.id   = req_request_id;
                        tail_in      = ptr_next(tail_ff);
                        count_in     = count_ff + CNT_W'(1);
                        pend_kind_in = KIND_PUSHED;
                     end else begin
                        pend_kind_in = KIND_FULL;
                     end
                     state_in = ST_EMIT;
                  end
                  OP_TAKE: begin
                     if (take_ok && mode_ff == MODE_RUNNING) begin
                        mem_req.rd_en = 1'b1;
                        state_in      = ST_TAKE_WAIT;
                     end else if (take_ok && mode_ff == MODE_PAUSED) begin
                        cur_in   = head_ff;
                        idx_in   = '0;
                        state_in = ST_SCAN_RD;
                     end else begin
                        pend_kind_in = KIND_NONE;
                        state_in     = ST_EMIT;
                     end
                  end
                  OP_PAUSE: begin
                     mode_in      = MODE_PAUSED;
                     pend_kind_in = KIND_ACK;
                     state_in     = ST_EMIT;
                  end
                  OP_RESUME: begin
                     mode_in      = MODE_RUNNING;
                     pend_kind_in = KIND_ACK;
                     state_in     = ST_EMIT;
                  end
                  OP_STOP: begin
                     mode_in  = MODE_STOPPED;
                     state_in = ST_DRAIN_RD;
                  end
                  default: begin
                     // unused codes are dropped without a result
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         // Running take: oldest entry comes back from memory
         ST_TAKE_WAIT: begin
            pend_kind_in = KIND_GRANTED;
            pend_id_in   = rd_data.id;
            head_in      = ptr_next(head_ff);
            count_in     = count_ff - CNT_W'(1);
            state_in     = ST_EMIT;
         end

         // Paused take: walk from the head to the first entry without hold
         ST_SCAN_RD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = cur_ff;
            state_in        = ST_SCAN_CHK;
         end

         ST_SCAN_CHK: begin
            if (!rd_data.hold) begin
               pend_kind_in = KIND_GRANTED;
               pend_id_in   = rd_data.id;
               if (idx_ff == '0) begin
                  // oldest entry: just advance the head
                  head_in  = ptr_next(head_ff);
                  count_in = count_ff - CNT_W'(1);
                  state_in = ST_EMIT;
               end else if (CNT_W'(idx_ff) == last_idx) begin
                  // newest entry: pull the tail back
                  tail_in  = cur_ff;
                  count_in = count_ff - CNT_W'(1);
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_MOVE_RD;
               end
            end else if (CNT_W'(idx_ff) == last_idx) begin
               pend_kind_in = KIND_NONE;
               pend_id_in   = '0;
               state_in     = ST_EMIT;
            end else begin
               cur_in   = ptr_next(cur_ff);
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SCAN_RD;
            end
         end

         // Close the gap: copy each later entry one slot toward the head
         ST_MOVE_RD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = ptr_next(cur_ff);
            state_in        = ST_MOVE_WR;
         end

         ST_MOVE_WR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = cur_ff;
            mem_req.wr_data = rd_data;
            cur_in          = ptr_next(cur_ff);
            idx_in          = idx_ff + 1'b1;
            if (CNT_W'(idx_ff + 1'b1) == last_idx) begin
               tail_in  = ptr_next(cur_ff);
               count_in = count_ff - CNT_W'(1);
               state_in = ST_EMIT;
            end else begin
               state_in = ST_MOVE_RD;
            end
         end

         // Stop: release queued ids oldest first, then acknowledge
         ST_DRAIN_RD: begin
            if (count_ff == '0) begin
               pend_kind_in = KIND_ACK;
               pend_id_in   = '0;
               pend_code_in = NO_CODE;
               pend_last_in = 1'b1;
               state_in     = ST_EMIT;
            end else begin
               mem_req.rd_en = 1'b1;
               state_in      = ST_DRAIN_WAIT;
            end
         end

         ST_DRAIN_WAIT: begin
            pend_kind_in = KIND_RELEASED;
            pend_id_in   = rd_data.id;
            pend_code_in = STOP_CODE;
            pend_last_in = 1'b0;
            head_in      = ptr_next(head_ff);
            count_in     = count_ff - CNT_W'(1);
            state_in     = ST_EMIT;
         end

         // Hand the pending result to the output register
         ST_EMIT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = pend_kind_ff;
               out_id_in    = pend_id_ff;
               out_code_in  = pend_code_ff;
               out_last_in  = pend_last_ff;
               if (pend_kind_ff == KIND_RELEASED) begin
                  state_in = ST_DRAIN_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_RUNNING;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         cur_ff       <= '0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         cur_ff       <= cur_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
      pend_kind_ff <= pend_kind_in;
      pend_id_ff   <= pend_id_in;
      pend_code_ff <= pend_code_in;
      pend_last_ff <= pend_last_in;
      out_kind_ff  <= out_kind_in;
      out_id_ff    <= out_id_in;
      out_code_ff  <= out_code_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid       = out_valid_ff;
   assign rsp_kind         = out_kind_ff;
   assign rsp_out_id       = out_id_ff;
   assign rsp_release_code = out_code_ff;
   assign rsp_last         = out_last_ff;

endmodule

// ===== hdl/pausable_request_queue.sv =====
// Top level of the pausable request queue.
`timescale 1ns / 1ps
// Ordered queue of up to 16 request ids kept in a circular slot memory with a
// registered read. A request is taken only while the block is idle and yields
// its results through a one-deep output register, so the next request can be
// taken while a result waits. A paused take reads the slots one at a time from
// the oldest and, when the granted entry sits between head and tail, copies
// every later entry down one slot. Stop releases each queued id, oldest first,
// then acknowledges with tlast set. Results stall on rsp_tready without loss.
module pausable_request_queue (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // request_id[31:0], deferrable[32], active_count[40:33]
   input  logic [2:0]  req_tuser,   // op[2:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // out_id[31:0], release_code[38:32]
   output logic [2:0]  rsp_tuser,   // kind[2:0]
   output logic        rsp_tlast,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import prq_pkg::*;

   logic [7:0]      take_limit;
   mem_req_type     mem_req;
   entry_type       rd_data;
   logic [ID_W-1:0] out_id;
   logic [6:0]      release_code;

   prq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .take_limit  (take_limit)
   );

   prq_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   prq_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .take_limit       (take_limit),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_op           (req_tuser),
      .req_request_id   (req_tdata[31:0]),
      .req_deferrable   (req_tdata[32]),
      .req_active_count (req_tdata[40:33]),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_kind         (rsp_tuser),
      .rsp_out_id       (out_id),
      .rsp_release_code (release_code),
      .rsp_last         (rsp_tlast),
      .mem_req          (mem_req),
      .rd_data          (rd_data)
   );

   // Pack result payload, zero fill to whole bytes
   assign rsp_tdata = {1'b0, release_code, out_id};

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the pausable request queue.
`timescale 1ns / 1ps
module tb;
   import prq_pkg::*;

   localparam int          CYCLE_LIMIT = 400000;
   localparam int          DRAIN_WAIT  = 50;
   localparam int          HOLD_CYCLES = 400;
   localparam logic [2:0]  LIMIT_ADDR  = {REG_TAKE_LIMIT, 2'b00};

   typedef enum logic [1:0] {
      MODE_RUNNING = 2'd0,
      MODE_STOPPED = 2'd1,
      MODE_PAUSED  = 2'd2
   } queue_mode_type;

   typedef struct packed {
      logic            hold;
      logic [ID_W-1:0] id;
   } slot_type;

   typedef struct packed {
      logic [2:0]      kind;
      logic [ID_W-1:0] id;
      logic [6:0]      code;
      logic            last;
   } result_rec_type;

   // Tracks queue contents and mode, and the results each request should cause
   class dispatch_tracker_type;
      slot_type       slots[$];
      result_rec_type due_results[$];
      queue_mode_type mode;
      logic [7:0]     take_limit;

      function new();
         mode       = MODE_RUNNING;
         take_limit = TAKE_LIMIT_RESET;
      endfunction

      function void add_due(input logic [2:0] kind, input logic [ID_W-1:0] id,
                            input logic [6:0] code, input logic last);
         result_rec_type r;
         r.kind = kind;
         r.id   = id;
         r.code = code;
         r.last = last;
         due_results.push_back(r);
      endfunction

      function int outstanding();
         return due_results.size();
      endfunction

      // Predict the results of one accepted request
      function void note_request(input logic [2:0] op, input logic [ID_W-1:0] id,
                                 input logic hold, input logic [7:0] active);
         slot_type s;
         int       pick;
         pick = -1;
         case (op)
            OP_PUSH: begin
               if (slots.size() < QUEUE_DEPTH) begin
                  s.id   = id;
                  s.hold = hold;
                  slots.push_back(s);
                  add_due(KIND_PUSHED, '0, NO_CODE, 1'b1);
               end else begin
                  add_due(KIND_FULL, '0, NO_CODE, 1'b1);
               end
            end
            OP_TAKE: begin
               if (active < take_limit && slots.size() > 0) begin
                  if (mode == MODE_RUNNING) begin
                     pick = 0;
                  end else if (mode == MODE_PAUSED) begin
                     // oldest entry without the hold flag
                     for (int i = 0; i < slots.size(); i++) begin
                        if (pick < 0 && !slots[i].hold) pick = i;
                     end
                  end
               end
               if (pick >= 0) begin
                  add_due(KIND_GRANTED, slots[pick].id, NO_CODE, 1'b1);
                  slots.delete(pick);
               end else begin
                  add_due(KIND_NONE, '0, NO_CODE, 1'b1);
               end
            end
            OP_PAUSE: begin
               mode = MODE_PAUSED;
               add_due(KIND_ACK, '0, NO_CODE, 1'b1);
            end
            OP_RESUME: begin
               mode = MODE_RUNNING;
               add_due(KIND_ACK, '0, NO_CODE, 1'b1);
            end
            OP_STOP: begin
               mode = MODE_STOPPED;
               foreach (slots[i]) add_due(KIND_RELEASED, slots[i].id, STOP_CODE, 1'b0);
               slots.delete();
               add_due(KIND_ACK, '0, NO_CODE, 1'b1);
            end
            default: begin
               // spare op codes are dropped
            end
         endcase
      endfunction

      // Compare one result with the oldest expectation; empty string if it matches
      function string check_result(input logic [2:0] kind, input logic [ID_W-1:0] id,
                                   input logic [6:0] code, input logic last);
         result_rec_type want;
         string          msg;
         if (due_results.size() == 0)
            return $sformatf("unexpected result kind %0d id %h", kind, id);
         want = due_results.pop_front();
         msg  = "";
         if (kind !== want.kind)
            msg = {msg, $sformatf(" kind %0d want %0d", kind, want.kind)};
         if (id !== want.id)
            msg = {msg, $sformatf(" id %h want %h", id, want.id)};
         if (code !== want.code)
            msg = {msg, $sformatf(" code %0d want %0d", code, want.code)};
         if (last !== want.last)
            msg = {msg, $sformatf(" last %b want %b", last, want.last)};
         return msg;
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // request_id[31:0], deferrable[32], active_count[40:33]
   logic [2:0]  req_tuser = OP_PUSH;   // op[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;   // out_id[31:0], release_code[38:32]
   logic [2:0]  rsp_tuser;   // kind[2:0]
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   dispatch_tracker_type tracker;
   int          error_count = 0;
   int          cycle_count = 0;
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   bit          pressure_on = 1'b0;
   logic        rsp_hold = 1'b0;

   pausable_request_queue u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Run-time guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   // Result side backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
      end else if (rsp_hold) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // One long receiver hold-off so the block backs up into the request side
   initial begin
      wait (pressure_on);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("tb: mismatch at cycle %0d:%s", cycle_count, what);
      error_count++;
   endtask

   // Result checker
   always @(posedge clock) begin
      string msg;
      if (!reset && rsp_tvalid && rsp_tready) begin
         msg = tracker.check_result(rsp_tuser, rsp_tdata[31:0], rsp_tdata[38:32], rsp_tlast);
         if (msg != "") report_mismatch(msg);
      end
   end

   // Offer one request, with random idle cycles first; returns after the handshake
   task automatic send_request(input logic [2:0] op, input logic [ID_W-1:0] id,
                               input logic hold, input logic [7:0] active);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'b0, active, hold, id};
      do @(posedge clock); while (!(req_tvalid && req_tready));
      tracker.note_request(op, id, hold, active);
   endtask

   // Wait until every result is in and the block has gone quiet
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (tracker.outstanding() > 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // Write take_limit, then read it back
   task automatic write_limit(input logic [7:0] value);
      logic [31:0] rd;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= LIMIT_ADDR;
      csr_pwdata  <= {24'b0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.take_limit = value;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rd = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (rd !== {24'b0, value})
         report_mismatch($sformatf(" take_limit read %h want %h", rd, value));
   endtask

   // Active count mostly under the limit so takes get granted
   function automatic logic [7:0] pick_active();
      if (tracker.take_limit > 0 && $urandom_range(0, 3) != 0)
         return 8'($urandom_range(0, tracker.take_limit - 1));
      return 8'($urandom_range(0, 255));
   endfunction

   // Random request sequences: push bursts, take runs, paused mixes, resumes, stops, noise
   task automatic run_traffic(input int goal);
      int sent;
      int pick;
      int len;
      logic [2:0] op;
      sent = 0;
      while (sent < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 6);
            repeat (len) send_request(OP_PUSH, $urandom, 1'($urandom), pick_active());
            sent += len;
         end else if (pick < 45) begin
            len = $urandom_range(1, 8);
            repeat (len) send_request(OP_TAKE, $urandom, 1'($urandom), pick_active());
            sent += len;
         end else if (pick < 62) begin
            send_request(OP_PAUSE, $urandom, 1'($urandom), 8'($urandom));
            len = $urandom_range(2, 8);
            repeat (len) begin
               op = ($urandom_range(0, 1) != 0) ? OP_PUSH : OP_TAKE;
               send_request(op, $urandom, 1'($urandom), pick_active());
            end
            sent += len + 1;
         end else if (pick < 72) begin
            send_request(OP_RESUME, $urandom, 1'($urandom), 8'($urandom));
            sent++;
         end else if (pick < 82) begin
            send_request(OP_STOP, $urandom, 1'($urandom), 8'($urandom));
            sent++;
         end else begin
            op = 3'($urandom_range(0, 7));
            send_request(op, $urandom, 1'($urandom), 8'($urandom));
            if (op <= OP_STOP) sent++;
         end
      end
   endtask

   initial begin
      logic [7:0] limit_val;
      tracker = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, every op, paused takes, limit refusal, stop drain
      send_request(OP_TAKE, 32'h0, 1'b0, 8'd0);
      send_request(OP_PUSH, 32'h0, 1'b0, 8'd0);
      send_request(OP_PUSH, 32'hFFFF_FFFF, 1'b1, 8'd255);
      send_request(OP_PUSH, 32'hA5A5_5A5A, 1'b0, 8'h55);
      send_request(OP_PAUSE, 32'h0, 1'b0, 8'd0);
      send_request(OP_TAKE, 32'h0, 1'b0, 8'd0);
      send_request(OP_TAKE, 32'hFFFF_FFFF, 1'b1, 8'd3);
      send_request(OP_TAKE, 32'h0, 1'b0, 8'd0);
      send_request(OP_PUSH, 32'h1234_5678, 1'b0, 8'd0);
      send_request(OP_TAKE, 32'h0, 1'b0, TAKE_LIMIT_RESET);
      send_request(OP_TAKE, 32'h0, 1'b0, 8'd255);
      send_request(OP_RESUME, 32'h0, 1'b0, 8'd0);
      send_request(OP_TAKE, 32'h0, 1'b0, 8'd0);
      send_request(OP_STOP, 32'h0, 1'b0, 8'd0);
      send_request(OP_TAKE, 32'h0, 1'b0, 8'd0);
      send_request(OP_PUSH, 32'h8000_0001, 1'b1, 8'hAA);
      send_request(OP_PUSH, 32'h7FFF_FFFE, 1'b0, 8'h01);
      send_request(OP_PAUSE, 32'h0, 1'b0, 8'd0);
      send_request(OP_STOP, 32'h0, 1'b0, 8'd0);
      send_request(OP_STOP, 32'hFFFF_FFFF, 1'b1, 8'd255);
      for (int k = int'(OP_STOP) + 1; k < 8; k++)
         send_request(3'(k), 32'hFFFF_FFFF, 1'b1, 8'd255);
      send_request(OP_RESUME, 32'h0, 1'b0, 8'd0);

      // Random phases, each with its own limit and one of four idle and stall patterns
      for (int ph = 0; ph < 6; ph++) begin
         settle_block();
         case (ph)
            0: limit_val = 8'd0;
            1: limit_val = 8'd255;
            2: limit_val = 8'd1;
            3: limit_val = 8'($urandom_range(2, 254));
            4: limit_val = TAKE_LIMIT_RESET;
            default: limit_val = 8'($urandom_range(0, 255));
         endcase
         write_limit(limit_val);
         case (ph % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 53; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 53; end
            default: begin send_idle_pct = 38; rsp_stall_pct = 38; end
         endcase
         if (ph == 3) begin
            // keep offering requests while the receiver holds off
            send_idle_pct = 0;
            pressure_on   = 1'b1;
            for (int k = 0; k < 40; k++)
               send_request((k % 3 == 2) ? OP_TAKE : OP_PUSH, $urandom, 1'($urandom),
                            pick_active());
            send_idle_pct = 38;
         end
         run_traffic(46);
      end

      settle_block();
      if (error_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
